FILE: sv/lswa_pkg.sv
package lswa_pkg;

  localparam int RAW_W     = 11;
  localparam int SAMPLE_W  = 10;
  localparam int LEVEL_W   = 12;
  localparam int CORR_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_AVERAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_CORR = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

FILE: sv/light_sensor_weighted_average.sv
// Light sensor weighted average.
// Input channel: raw_sample_i moves on a transfer when in_valid_i is high and in_stall_o
// is low. The reading is saturated to 1023. With use_average set it is pushed into a
// window of WINDOW_LEN slots and smoothed by a linearly weighted moving average.
// Output channel: light_level_o (1023 - value + offset_correction, signed) moves when
// out_valid_o is high and out_stall_i is low. Exactly one result per input.
// Config channel: cfg_index_i 0 = use_average, 1 = offset_correction (signed);
// cfg_ready_o is always high, other indexes are dropped. Write only while idle.
// With averaging: the window is walked one slot per cycle (one shared multiply-
// accumulate), then the sum is divided one quotient bit per cycle. Without averaging
// the sample goes straight to the result. Either way a new item is taken only once
// the result of the last one has been written to the output register.
// in_stall_o stays high while an item is being worked on.
// Stall: the result sits in the output register; the next item may already be taken,
// but its result waits until the held one has moved.
// Reset: the window is cleared to zero, both registers clear to zero, no output valid.
module light_sensor_weighted_average #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [lswa_pkg::RAW_W-1:0]           raw_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lswa_pkg::LEVEL_W-1:0]  light_level_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lswa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lswa_pkg::CORR_W-1:0]          cfg_data_i
);

  localparam int SW     = lswa_pkg::SAMPLE_W;
  localparam int WT_MAX = WINDOW_LEN + (WINDOW_LEN * (WINDOW_LEN - 1)) / 2;
  localparam int WT_W   = $clog2(WT_MAX + 1);
  localparam int SUM_W  = $clog2(1023 * WT_MAX + 1);
  localparam int CNT_W  = ($clog2(WINDOW_LEN) > 4) ? $clog2(WINDOW_LEN) : 4;
  localparam int WGT_W  = $clog2(WINDOW_LEN + 1);

  lswa_pkg::state_e state_q, state_d;

  logic [SW-1:0]     win_q [WINDOW_LEN];
  logic [SW-1:0]     sample_q;
  logic [SUM_W-1:0]  acc_q, acc_d;
  logic [WT_W-1:0]   wt_q, wt_d;
  logic [WT_W-1:0]   rem_q, rem_d;
  logic [SW-1:0]     lo_q, lo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              use_avg_q;
  logic [lswa_pkg::CORR_W-1:0] corr_q;
  logic              out_valid_q;
  logic signed [lswa_pkg::LEVEL_W-1:0] level_q;

  logic              in_xfer;
  logic              out_free;
  logic              walk_last;
  logic              div_last;
  logic [SW-1:0]     sample_sat;
  logic [SW-1:0]     win_new;
  logic [WGT_W-1:0]  weight;
  logic [SUM_W-1:0]  product;
  logic [WT_W:0]     trial;
  logic              trial_ge;
  logic [SW-1:0]     value;
  logic [lswa_pkg::LEVEL_W-1:0] level_d;

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign light_level_o = level_q;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign walk_last  = (cnt_q == CNT_W'(WINDOW_LEN - 1));
  assign div_last   = (cnt_q == CNT_W'(lswa_pkg::DIV_STEPS - 1));
  assign sample_sat = raw_sample_i[lswa_pkg::RAW_W-1] ? lswa_pkg::SAMPLE_MAX
                                                      : raw_sample_i[SW-1:0];

  assign weight  = WGT_W'(cnt_q) + WGT_W'(1);
  assign product = SUM_W'(win_q[1]) * SUM_W'(weight);
  assign win_new = walk_last ? win_q[0] : ((win_q[1] != '0) ? win_q[1] : win_q[0]);

  assign trial    = {rem_q, lo_q[SW-1]};
  assign trial_ge = (trial >= {1'b0, wt_q});

  assign value   = use_avg_q ? lo_q : sample_q;
  assign level_d = 12'(lswa_pkg::SAMPLE_MAX) - {2'b00, value}
                 + {{(lswa_pkg::LEVEL_W - lswa_pkg::CORR_W){corr_q[lswa_pkg::CORR_W-1]}}, corr_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lswa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = use_avg_q ? lswa_pkg::ST_WALK : lswa_pkg::ST_DONE;
        end
      end
      lswa_pkg::ST_WALK: begin
        if (walk_last) begin
          state_d = lswa_pkg::ST_DIV;
        end
      end
      lswa_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = lswa_pkg::ST_DONE;
        end
      end
      lswa_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lswa_pkg::ST_IDLE;
        end
      end
      default: state_d = lswa_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o = 1'b1;
    acc_d      = acc_q;
    wt_d       = wt_q;
    rem_d      = rem_q;
    lo_d       = lo_q;
    cnt_d      = cnt_q;
    case (state_q)
      lswa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        acc_d      = SUM_W'(sample_sat) * SUM_W'(WINDOW_LEN);
        wt_d       = WT_W'(WINDOW_LEN);
        cnt_d      = '0;
      end
      lswa_pkg::ST_WALK: begin
        if (walk_last) begin
          cnt_d = '0;
          rem_d = WT_W'(acc_q >> SW);
          lo_d  = acc_q[SW-1:0];
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
          if (win_q[1] != '0) begin
            acc_d = acc_q + product;
            wt_d  = wt_q + WT_W'(weight);
          end
        end
      end
      lswa_pkg::ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        rem_d = trial_ge ? WT_W'(trial - {1'b0, wt_q}) : trial[WT_W-1:0];
        lo_d  = {lo_q[SW-2:0], trial_ge};
      end
      lswa_pkg::ST_DONE: begin
        in_stall_o = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lswa_pkg::ST_IDLE;
      cnt_q       <= '0;
      use_avg_q   <= 1'b0;
      corr_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lswa_pkg::CFG_USE_AVERAGE: use_avg_q <= cfg_data_i[0];
          lswa_pkg::CFG_OFFSET_CORR: corr_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer && use_avg_q) begin
        win_q[WINDOW_LEN-1] <= sample_sat;
      end else if (state_q == lswa_pkg::ST_WALK) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WINDOW_LEN-1] <= win_new;
      end
      if (state_q == lswa_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    wt_q  <= wt_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    if (in_xfer) begin
      sample_q <= sample_sat;
    end
    if (state_q == lswa_pkg::ST_DONE && out_free) begin
      level_q <= signed'(level_d);
    end
  end

  a_wt_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lswa_pkg::ST_DIV |-> wt_q >= WT_W'(WINDOW_LEN))
    else $error("weight total below window length");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lswa_pkg::ST_DIV |-> rem_q < wt_q)
    else $error("divider remainder not below divisor");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !use_avg_q |=> state_q == lswa_pkg::ST_DONE)
    else $error("pass-through item did not go straight to result");

  a_walk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lswa_pkg::ST_WALK |-> cnt_q < CNT_W'(WINDOW_LEN))
    else $error("window walk counter out of range");

endmodule

FILE: verif/light_sensor_weighted_average_tb.sv
`timescale 1ns / 100ps

module light_sensor_weighted_average_tb;

  localparam int RAW_W     = lswa_pkg::RAW_W;
  localparam int SAMPLE_W  = lswa_pkg::SAMPLE_W;
  localparam int LEVEL_W   = lswa_pkg::LEVEL_W;
  localparam int CORR_W    = lswa_pkg::CORR_W;
  localparam int CFG_IDX_W = lswa_pkg::CFG_IDX_W;

  localparam int WINDOW_LEN      = 8;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 119;
  localparam int SETTLE_CYCLES   = WINDOW_LEN + 12;
  localparam int CYCLE_LIMIT     = 600000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [RAW_W-1:0]           raw_sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [LEVEL_W-1:0]  light_level_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CORR_W-1:0]          cfg_data_i = '0;

  // mirror of the block state and registers
  logic [SAMPLE_W-1:0]        history_m [WINDOW_LEN] = '{default: '0};
  logic                       use_average_m = 1'b0;
  logic signed [CORR_W-1:0]   offset_corr_m = '0;

  logic [RAW_W-1:0]           pending_samples [$];
  logic signed [LEVEL_W-1:0]  expected_levels [$];

  logic                       calm = 1'b0;
  int                         burst_left = 0;
  int                         gap_left = 0;
  logic [15:0]                stall_pat = '0;
  int                         stall_age = 0;
  int                         cycles = 0;
  int                         mismatches = 0;
  int                         samples_sent = 0;
  int                         averaged_samples = 0;
  int                         levels_checked = 0;
  int                         settings_applied = 0;

  light_sensor_weighted_average #(
    .WINDOW_LEN(WINDOW_LEN)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .light_level_o(light_level_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [LEVEL_W-1:0] light_level_of(
    input logic [RAW_W-1:0] raw
  );
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] value;
    int unsigned         acc;
    int unsigned         weight;
    sample = (raw > {1'b0, lswa_pkg::SAMPLE_MAX}) ? lswa_pkg::SAMPLE_MAX
                                                   : raw[SAMPLE_W-1:0];
    value  = sample;
    if (use_average_m) begin
      history_m[WINDOW_LEN-1] = sample;
      acc    = 0;
      weight = WINDOW_LEN;
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        if (history_m[i+1] != '0) begin
          history_m[i] = history_m[i+1];
          acc    += history_m[i] * (i + 1);
          weight += i + 1;
        end
      end
      acc  += sample * WINDOW_LEN;
      value = SAMPLE_W'(acc / weight);
    end
    return LEVEL_W'(int'(lswa_pkg::SAMPLE_MAX) - int'(value) + int'(offset_corr_m));
  endfunction

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAW_W'($urandom_range(1024, 2047));
      2: return $urandom_range(0, 1) ? RAW_W'(lswa_pkg::SAMPLE_MAX) : RAW_W'(1);
      3: return RAW_W'($urandom_range(1, 15));
      default: return RAW_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CORR_W-1:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lswa_pkg::CFG_USE_AVERAGE: use_average_m = data[0];
      lswa_pkg::CFG_OFFSET_CORR: offset_corr_m = data;
      default: ;
    endcase
    settings_applied++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (use_average_m) averaged_samples++;
        expected_levels.push_back(light_level_of(raw_sample_i));
        samples_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid_i   <= 1'b1;
          raw_sample_i <= pending_samples.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if (calm) gap_left = 0;
            else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(8, 30);
            else gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic signed [LEVEL_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: light level %0d with no sample outstanding", $time, light_level_o);
          mismatches++;
        end else begin
          want = expected_levels.pop_front();
          levels_checked++;
          if (light_level_o !== want) begin
            $display("%0t: light_level mismatch, expected %0d, got %0d",
                     $time, want, light_level_o);
            mismatches++;
          end
        end
      end
      stall_age++;
      if (stall_age >= 50) begin
        stall_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pat = 16'($urandom) & 16'($urandom);
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom) | 16'($urandom);
          default: stall_pat = '0;
        endcase
      end
      out_stall_i <= calm ? 1'b0 : stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d levels still outstanding",
               $time, cycles, expected_levels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [CORR_W-1:0] corr;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers at their reset values
    @(negedge clk_i);
    pending_samples = '{11'd0, 11'd2047};
    wait_idle();

    // direct path, most negative correction
    write_setting(lswa_pkg::CFG_USE_AVERAGE, 8'hFE);
    write_setting(lswa_pkg::CFG_OFFSET_CORR, 8'h80);
    @(negedge clk_i);
    pending_samples = '{11'd0, 11'd1023, 11'd1024, 11'd2047, 11'd1, 11'h555, 11'h2AA};
    wait_idle();

    // averaging, most positive correction, spare indexes dropped
    write_setting(lswa_pkg::CFG_USE_AVERAGE, 8'h01);
    write_setting(lswa_pkg::CFG_OFFSET_CORR, 8'h7F);
    write_setting(CFG_SPARE_LO, 8'h00);
    write_setting(CFG_SPARE_HI, 8'hFF);
    @(negedge clk_i);
    pending_samples = '{11'd1023, 11'd0, 11'd512, 11'd2047, 11'd0, 11'd0,
                        11'd1, 11'd700, 11'd1023, 11'd300, 11'd5, 11'd0};
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: corr = 8'h80;
        1: corr = 8'h7F;
        default: corr = 8'($urandom);
      endcase
      if ($urandom_range(0, 1)) write_setting(lswa_pkg::CFG_OFFSET_CORR, corr);
      write_setting(lswa_pkg::CFG_USE_AVERAGE,
                    {7'($urandom), 1'($urandom_range(0, 3) != 0)});
      if ($urandom_range(0, 1)) write_setting(lswa_pkg::CFG_OFFSET_CORR, corr);
      if ($urandom_range(0, 2) == 0)
        write_setting($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom));
      @(negedge clk_i);
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_samples.push_back(random_raw());
      wait_idle();
    end

    $display("Checked %0d light levels from %0d samples, %0d smoothed by the window",
             levels_checked, samples_sent, averaged_samples);
    $display("Applied %0d register writes across %0d phases", settings_applied,
             NUM_PHASES + 3);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
